// File: design/tmd_pkg.sv
// Package of the typed message deframer: sizes, codes and stage records.
`timescale 1ns / 1ps

package tmd_pkg;

	localparam int NUM_TYPES   = 64;
	localparam int NUM_STREAMS = 2;

	localparam int IDX_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int TBL_DEPTH = NUM_STREAMS * NUM_TYPES;
	localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 4;

	typedef enum logic {
		OP_REG  = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_LEN  = 2'd0,
		PH_TYPE = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		K_NONE    = 3'd0,
		K_DATA    = 3'd1,
		K_EMPTY   = 3'd2,
		K_NOTYPE  = 3'd3,
		K_SIZE    = 3'd4,
		K_REFUSED = 3'd5
	} kind_t;

	// item between acceptance and the table lookup
	typedef struct packed {
		op_t               op;
		logic              host;
		logic              strm;
		phase_t            ph;
		logic [7:0]        type8;
		logic              inrange;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        esz;
		logic [7:0]        rxb;
		logic [7:0]        len;
		logic [7:0]        ftype;
		logic              fin;
		logic              fwd;
		logic [7:0]        fwd_size;
	} s1_t;

	typedef struct packed {
		kind_t      kind;
		logic       strm;
		logic [7:0] msg_type;
		logic [7:0] pay;
		logic       last;
		logic [7:0] exp_size;
	} res_t;

endpackage

// File: design/typed_message_deframer.sv
// Typed message deframer: framing state, size table and result register.
`timescale 1ns / 1ps

// Deframes two byte streams of messages (length byte, type byte, payload).
// Each input transaction is either a table registration (tuser op low) or one
// received byte (op high); each gives exactly one output transaction, kind
// "nothing" included. Throughput is one transaction per cycle on both streams
// interleaved freely, unless m_tready holds the output register. The size table
// RAM read is registered. Framing counters per stream live in flops and advance
// at acceptance; the table lookup, error decision and skip flag are resolved
// from the stage 1 register. A registration immediately followed by a lookup of
// the same entry is forwarded around the RAM. Table valid marks are flops
// cleared by reset, so no clearing pass is needed after reset.
module typed_message_deframer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [5:0] entry_type, [13:6] entry_size, [21:14] rx_byte, [23:22] zero
	input  logic [tmd_pkg::IN_DATA_W-1:0]   s_tdata,
	// [0] op, [1] stream_is_host
	input  logic [tmd_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] msg_type, [15:8] payload_byte, [23:16] expected_size
	output logic [tmd_pkg::OUT_DATA_W-1:0]  m_tdata,
	// [2:0] kind, [3] out_stream
	output logic [tmd_pkg::OUT_USER_W-1:0]  m_tuser,
	output logic                            m_tlast
);
	import tmd_pkg::*;

	// input decode
	op_t               op_in;
	logic              host_in;
	logic              s_in;
	logic [7:0]        type8_in;
	logic              inrange_in;
	logic [IDX_W-1:0]  idx_in;
	logic [ADDR_W-1:0] rd_addr;
	phase_t            eff_ph;
	logic [7:0]        left_dec;
	logic              fin_in;
	logic              accept;

	// per-stream framing state
	phase_t     phase_q [NUM_STREAMS];
	logic [7:0] len_q   [NUM_STREAMS];
	logic [7:0] ftype_q [NUM_STREAMS];
	logic [7:0] left_q  [NUM_STREAMS];
	logic       skip_q  [NUM_STREAMS];

	// table: valid marks in flops, sizes in RAM
	logic [TBL_DEPTH-1:0] valid_q;
	logic [7:0]           size_mem [TBL_DEPTH];
	logic [7:0]           rdata_q;

	s1_t  s1_q;
	logic s1_valid_q;
	logic adv;
	logic proc;

	logic       tab_vld;
	logic [7:0] tab_size;
	logic       type_err;
	logic       wr_en;
	res_t       res;
	res_t       out_q;
	logic       m_tvalid_q;

	// handshake: the result register frees the stage behind it
	assign adv      = !m_tvalid_q || m_tready;
	assign proc     = s1_valid_q && adv;
	assign s_tready = !s1_valid_q || adv;
	assign accept   = s_tvalid && s_tready;

	assign op_in    = op_t'(s_tuser[0]);
	assign host_in  = s_tuser[1];
	assign s_in     = (NUM_STREAMS > 1) ? host_in : 1'b0;
	assign type8_in = (op_in == OP_REG) ? {2'b00, s_tdata[5:0]} : s_tdata[21:14];
	assign inrange_in = {1'b0, type8_in} < 9'(NUM_TYPES);
	assign idx_in   = type8_in[IDX_W-1:0];
	assign rd_addr  = s_in ? (ADDR_W'(NUM_TYPES) + ADDR_W'(idx_in)) : ADDR_W'(idx_in);
	assign left_dec = left_q[s_in] - 8'd1;
	assign fin_in   = (left_dec == 8'd0);

	always_comb begin
		case (phase_q[s_in])
			PH_TYPE: eff_ph = PH_TYPE;
			PH_BODY: eff_ph = PH_BODY;
			default: eff_ph = PH_LEN;
		endcase
	end

	// framing counters advance at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STREAMS; i++) begin
				phase_q[i] <= PH_LEN;
				len_q[i]   <= 8'd0;
				ftype_q[i] <= 8'd0;
				left_q[i]  <= 8'd0;
			end
		end else if (accept && op_in == OP_BYTE) begin
			case (eff_ph)
				PH_TYPE: begin
					ftype_q[s_in] <= s_tdata[21:14];
					left_q[s_in]  <= len_q[s_in];
					phase_q[s_in] <= (len_q[s_in] == 8'd0) ? PH_LEN : PH_BODY;
				end
				PH_BODY: begin
					left_q[s_in] <= left_dec;
					if (fin_in) begin
						phase_q[s_in] <= PH_LEN;
					end
				end
				default: begin
					len_q[s_in]   <= s_tdata[21:14];
					phase_q[s_in] <= PH_TYPE;
				end
			endcase
		end
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q.op       <= op_in;
			s1_q.host     <= host_in;
			s1_q.strm     <= s_in;
			s1_q.ph       <= eff_ph;
			s1_q.type8    <= type8_in;
			s1_q.inrange  <= inrange_in;
			s1_q.addr     <= rd_addr;
			s1_q.esz      <= s_tdata[13:6];
			s1_q.rxb      <= s_tdata[21:14];
			s1_q.len      <= len_q[s_in];
			s1_q.ftype    <= ftype_q[s_in];
			s1_q.fin      <= fin_in;
			// registration to the same entry retiring this cycle
			s1_q.fwd      <= wr_en && (s1_q.addr == rd_addr);
			s1_q.fwd_size <= s1_q.esz;
		end
	end

	// size RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_mem[s1_q.addr] <= s1_q.esz;
		end
		if (accept) begin
			rdata_q <= size_mem[rd_addr];
		end
	end

	assign tab_vld  = valid_q[s1_q.addr];
	assign tab_size = s1_q.fwd ? s1_q.fwd_size : rdata_q;
	assign type_err = !s1_q.inrange || !tab_vld || (s1_q.len != tab_size);

	// result and table update for the item in stage 1
	always_comb begin
		res      = '0;
		res.kind = K_NONE;
		res.strm = s1_q.host;
		wr_en    = 1'b0;
		if (s1_q.op == OP_REG) begin
			if (!s1_q.inrange) begin
				res.kind     = K_REFUSED;
				res.msg_type = s1_q.type8;
			end else if (tab_vld) begin
				res.kind     = K_REFUSED;
				res.msg_type = s1_q.type8;
				res.exp_size = tab_size;
			end else begin
				wr_en = proc;
			end
		end else begin
			case (s1_q.ph)
				PH_TYPE: begin
					if (!s1_q.inrange || !tab_vld) begin
						res.kind     = K_NOTYPE;
						res.msg_type = s1_q.type8;
					end else if (s1_q.len != tab_size) begin
						res.kind     = K_SIZE;
						res.msg_type = s1_q.type8;
						res.exp_size = tab_size;
					end else if (s1_q.len == 8'd0) begin
						res.kind     = K_EMPTY;
						res.msg_type = s1_q.type8;
					end
				end
				PH_BODY: begin
					if (!skip_q[s1_q.strm]) begin
						res.kind     = K_DATA;
						res.msg_type = s1_q.ftype;
						res.pay      = s1_q.rxb;
						res.last     = s1_q.fin;
					end
				end
				default: begin
					res.kind = K_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[s1_q.addr] <= 1'b1;
		end
	end

	// skip flag: set by a bad header with payload, cleared by any other header and at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STREAMS; i++) begin
				skip_q[i] <= 1'b0;
			end
		end else if (proc && s1_q.op == OP_BYTE) begin
			case (s1_q.ph)
				PH_TYPE: skip_q[s1_q.strm] <= type_err && (s1_q.len != 8'd0);
				PH_BODY: begin
					if (s1_q.fin) begin
						skip_q[s1_q.strm] <= 1'b0;
					end
				end
				default: skip_q[s1_q.strm] <= skip_q[s1_q.strm];
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.exp_size, out_q.pay, out_q.msg_type};
	assign m_tuser  = {out_q.strm, out_q.kind};
	assign m_tlast  = out_q.last;

	// a registration marks its entry valid
	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(s1_q.addr)])
		else $error("table entry not marked valid after registration");

	// a header with non-zero length always opens a body
	a_type_to_body: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_in == OP_BYTE && eff_ph == PH_TYPE && len_q[s_in] != 8'd0)
		|=> phase_q[$past(s_in)] == PH_BODY)
		else $error("framing did not enter payload phase");

	// an empty stage 1 never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input stalled with empty pipeline");

	// same-entry lookup behind a registration takes the forwarded size
	a_forward_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wr_en && s1_q.addr == rd_addr) |=> s1_q.fwd)
		else $error("missed table forwarding");

endmodule
